// ----- design/aging_accumulator_table_assert.svh -----
// Assertion macros for the checker file.
`ifndef AGING_ACCUMULATOR_TABLE_ASSERT_SVH
`define AGING_ACCUMULATOR_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/aat_pkg.sv -----
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types, codes and the control store of the aging accumulator table.
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int KEY_W     = 16;
    localparam int AMT_W     = 16;
    localparam int TIME_W    = 32;
    localparam int SUM_W     = 31;
    localparam int IDX_OUT_W = 4;
    localparam int ENTRY_W   = KEY_W + TIME_W + SUM_W;

    localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [TIME_W-1:0] EXPIRE_RESET = 32'd10000;

    // outcome codes
    localparam logic [1:0] OUTCOME_UPDATED  = 2'd0;
    localparam logic [1:0] OUTCOME_REPLACED = 2'd1;
    localparam logic [1:0] OUTCOME_FULL     = 2'd2;

    // register index of expire_ms
    localparam logic REG_EXPIRE = 1'b0;

    // microprogram steps
    typedef logic [1:0] step_t;
    localparam step_t STEP_IDLE = 2'd0;
    localparam step_t STEP_SCAN = 2'd1;
    localparam step_t STEP_WB   = 2'd2;

    // jump conditions
    typedef enum logic [1:0] {
        COND_IN_VALID  = 2'd0,
        COND_SCAN_DONE = 2'd1,
        COND_OUT_FREE  = 2'd2,
        COND_NEVER     = 2'd3
    } cond_t;

    // one control word: actions plus a conditional jump (else hold the step)
    typedef struct packed {
        logic  do_latch;
        logic  do_scan;
        logic  do_write;
        cond_t cond;
        step_t target;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic scan_done;
        logic out_free;
    } status_t;

    function automatic ctrl_t ucode_word(input step_t step);
        ctrl_t w;
        w = '{do_latch: 1'b1, do_scan: 1'b0, do_write: 1'b0,
              cond: COND_IN_VALID, target: STEP_SCAN};
        unique case (step)
            STEP_IDLE: w = '{do_latch: 1'b1, do_scan: 1'b0, do_write: 1'b0,
                             cond: COND_IN_VALID, target: STEP_SCAN};
            STEP_SCAN: w = '{do_latch: 1'b0, do_scan: 1'b1, do_write: 1'b0,
                             cond: COND_SCAN_DONE, target: STEP_WB};
            STEP_WB:   w = '{do_latch: 1'b0, do_scan: 1'b0, do_write: 1'b1,
                             cond: COND_OUT_FREE, target: STEP_IDLE};
            default:   w = '{do_latch: 1'b0, do_scan: 1'b0, do_write: 1'b0,
                             cond: COND_NEVER, target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- design/aat_ram.sv -----
// ----------------------------------------------------------------------------
// aat_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/aat_seq.sv -----
// ----------------------------------------------------------------------------
// aat_seq
// Step counter and control store; conditional jump or hold each cycle.
// ----------------------------------------------------------------------------
module aat_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  aat_pkg::status_t status,
    output aat_pkg::ctrl_t   ctrl,
    output logic             fire
);

    aat_pkg::step_t step_reg;
    aat_pkg::step_t step_next;

    assign ctrl = aat_pkg::ucode_word(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            aat_pkg::COND_IN_VALID:  fire = status.in_valid;
            aat_pkg::COND_SCAN_DONE: fire = status.scan_done;
            aat_pkg::COND_OUT_FREE:  fire = status.out_free;
            aat_pkg::COND_NEVER:     fire = 1'b0;
        endcase
        step_next = fire ? ctrl.target : step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= aat_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/aat_dp.sv -----
// ----------------------------------------------------------------------------
// aat_dp
// Slot store, scan compare, write-back and output register.
// ----------------------------------------------------------------------------
module aat_dp #(
    parameter int SLOTS = 16,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  aat_pkg::ctrl_t                    ctrl,
    input  logic                              fire,
    output aat_pkg::status_t                  status,
    input  logic [aat_pkg::TIME_W-1:0]        expire_ms,
    input  logic                              in_valid,
    input  logic [aat_pkg::KEY_W-1:0]         entry_key,
    input  logic [aat_pkg::AMT_W-1:0]         amount,
    input  logic [aat_pkg::TIME_W-1:0]        now_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [aat_pkg::SUM_W-1:0]         total,
    output logic [1:0]                        outcome,
    output logic [aat_pkg::IDX_OUT_W-1:0]     slot_index
);

    localparam int KW = aat_pkg::KEY_W;
    localparam int TW = aat_pkg::TIME_W;
    localparam int SW = aat_pkg::SUM_W;
    localparam int EW = aat_pkg::ENTRY_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // control registers
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             match_reg, match_next;
    logic             elig_reg, elig_next;
    logic             out_valid_reg, out_valid_next;

    // payload registers
    logic [KW-1:0]               key_reg, key_next;
    logic [aat_pkg::AMT_W-1:0]   amt_reg, amt_next;
    logic [TW-1:0]               now_reg, now_next;
    logic [IDX_W-1:0]            match_idx_reg, match_idx_next;
    logic [SW-1:0]               match_sum_reg, match_sum_next;
    logic [IDX_W-1:0]            best_idx_reg, best_idx_next;
    logic [TW-1:0]               best_time_reg, best_time_next;
    logic [SW-1:0]               total_reg, total_next;
    logic [1:0]                  outcome_reg, outcome_next;
    logic [aat_pkg::IDX_OUT_W-1:0] slot_index_reg, slot_index_next;

    // RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [EW-1:0]    ram_rdata;

    // entry under test
    logic [KW-1:0] e_key;
    logic [TW-1:0] e_time;
    logic [SW-1:0] e_sum;
    logic [TW-1:0] e_age;
    logic [SW:0]   sum_wide;
    logic [SW-1:0] sum_sat;
    logic          hit;
    logic          eligible;
    logic          out_free;

    aat_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        // a slot never written reads as cleared
        if (valid_reg[idx_reg])
        begin
            e_key  = ram_rdata[EW-1 -: KW];
            e_time = ram_rdata[SW +: TW];
            e_sum  = ram_rdata[SW-1:0];
        end
        else
        begin
            e_key  = '0;
            e_time = '0;
            e_sum  = '0;
        end
        e_age    = now_reg - e_time;
        hit      = (e_key == key_reg);
        eligible = (e_age >= expire_ms);
        sum_wide = {1'b0, e_sum} + (SW + 1)'(amt_reg);
        sum_sat  = sum_wide[SW] ? aat_pkg::SUM_MAX : sum_wide[SW-1:0];
        out_free = !out_valid_reg || out_ready;

        status.in_valid  = in_valid;
        status.scan_done = hit || (idx_reg == LAST_IDX);
        status.out_free  = out_free;
    end

    always_comb
    begin
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        match_next      = match_reg;
        elig_next       = elig_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        key_next        = key_reg;
        amt_next        = amt_reg;
        now_next        = now_reg;
        match_idx_next  = match_idx_reg;
        match_sum_next  = match_sum_reg;
        best_idx_next   = best_idx_reg;
        best_time_next  = best_time_reg;
        total_next      = total_reg;
        outcome_next    = outcome_reg;
        slot_index_next = slot_index_reg;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        ram_wdata       = {key_reg, now_reg, SW'(amt_reg)};
        ram_re          = 1'b0;
        ram_raddr       = '0;

        if (ctrl.do_latch && fire)
        begin
            key_next   = entry_key;
            amt_next   = amount;
            now_next   = now_ms;
            idx_next   = '0;
            match_next = 1'b0;
            elig_next  = 1'b0;
            ram_re     = 1'b1;
            ram_raddr  = '0;
        end

        if (ctrl.do_scan)
        begin
            // prefetch the next slot while this one is compared
            idx_next  = IDX_W'(idx_reg + IDX_W'(1));
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(idx_reg + IDX_W'(1));
            if (hit)
            begin
                match_next     = 1'b1;
                match_idx_next = idx_reg;
                match_sum_next = sum_sat;
            end
            else if (eligible && (!elig_reg || (e_time < best_time_reg)))
            begin
                elig_next      = 1'b1;
                best_idx_next  = idx_reg;
                best_time_next = e_time;
            end
        end

        if (ctrl.do_write && fire)
        begin
            out_valid_next = 1'b1;
            priority if (match_reg)
            begin
                ram_we          = 1'b1;
                ram_waddr       = match_idx_reg;
                ram_wdata       = {key_reg, now_reg, match_sum_reg};
                valid_next[match_idx_reg] = 1'b1;
                total_next      = match_sum_reg;
                outcome_next    = aat_pkg::OUTCOME_UPDATED;
                slot_index_next = aat_pkg::IDX_OUT_W'(match_idx_reg);
            end
            else if (elig_reg)
            begin
                ram_we          = 1'b1;
                ram_waddr       = best_idx_reg;
                ram_wdata       = {key_reg, now_reg, SW'(amt_reg)};
                valid_next[best_idx_reg] = 1'b1;
                total_next      = SW'(amt_reg);
                outcome_next    = aat_pkg::OUTCOME_REPLACED;
                slot_index_next = aat_pkg::IDX_OUT_W'(best_idx_reg);
            end
            else
            begin
                total_next      = '0;
                outcome_next    = aat_pkg::OUTCOME_FULL;
                slot_index_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            match_reg     <= 1'b0;
            elig_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
            match_reg     <= match_next;
            elig_reg      <= elig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        amt_reg        <= amt_next;
        now_reg        <= now_next;
        match_idx_reg  <= match_idx_next;
        match_sum_reg  <= match_sum_next;
        best_idx_reg   <= best_idx_next;
        best_time_reg  <= best_time_next;
        total_reg      <= total_next;
        outcome_reg    <= outcome_next;
        slot_index_reg <= slot_index_next;
    end

    assign out_valid  = out_valid_reg;
    assign total      = total_reg;
    assign outcome    = outcome_reg;
    assign slot_index = slot_index_reg;

endmodule

// ----- design/aging_accumulator_table.sv -----
// ----------------------------------------------------------------------------
// aging_accumulator_table
// Keyed running-sum table with age-based slot replacement.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            word
//  --------  ---------  -------------------  ---------------------------------
//  input     in         in_valid / in_ready  entry_key, amount, now_ms
//  result    out        out_valid/out_ready  total, outcome, slot_index
//  config    in         APB, pready = 1      expire_ms at byte address 0
//
//  Steps: an accept step, then a scan of the slots in order (stops at the
//  first key hit, at most SLOTS slots), then a write-back step; the scan
//  walks the single RAM read port; no new word is taken until write-back.
//  Reset: slot table reads as cleared through per-slot valid flops, no sweep;
//  expire_ms returns to 10000.
//  Stalls: the result sits in an output register; a new word is taken while
//  it waits, and write-back holds only if the previous result is still there.
//
module aging_accumulator_table #(
    parameter int SLOTS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input word
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [aat_pkg::KEY_W-1:0]     entry_key,
    input  logic [aat_pkg::AMT_W-1:0]     amount,
    input  logic [aat_pkg::TIME_W-1:0]    now_ms,
    // result word
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [aat_pkg::SUM_W-1:0]     total,
    output logic [1:0]                    outcome,
    output logic [aat_pkg::IDX_OUT_W-1:0] slot_index,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    aat_pkg::ctrl_t   ctrl;
    aat_pkg::status_t status;
    logic             fire;

    logic [aat_pkg::TIME_W-1:0] expire_reg;
    logic [aat_pkg::TIME_W-1:0] expire_next;
    logic                       cfg_write;

    // ---- configuration register ------------------------------------------
    // paddr[2] is the register index; only index 0 exists.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        expire_next = expire_reg;
        if (cfg_write && (paddr[2] == aat_pkg::REG_EXPIRE))
        begin
            expire_next = pwdata;
        end
        prdata = (paddr[2] == aat_pkg::REG_EXPIRE) ? expire_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expire_reg <= aat_pkg::EXPIRE_RESET;
        end
        else
        begin
            expire_reg <= expire_next;
        end
    end

    // ---- sequencer ---------------------------------------------------------
    // ready only in the accept step of the microprogram
    assign in_ready = ctrl.do_latch;

    aat_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl),
        .fire   (fire)
    );

    // ---- datapath ----------------------------------------------------------
    aat_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .fire       (fire),
        .status     (status),
        .expire_ms  (expire_reg),
        .in_valid   (in_valid),
        .entry_key  (entry_key),
        .amount     (amount),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .total      (total),
        .outcome    (outcome),
        .slot_index (slot_index)
    );

endmodule

// ----- design/aat_checker.sv -----
// ----------------------------------------------------------------------------
// aat_checker
// Port-level checks on the aging accumulator table, bound to the top level.
// ----------------------------------------------------------------------------
`include "aging_accumulator_table_assert.svh"

module aat_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [aat_pkg::SUM_W-1:0]     total,
    input logic [1:0]                    outcome,
    input logic [aat_pkg::IDX_OUT_W-1:0] slot_index
);

    // busy scanning right after a word is taken
    `AAT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // stalled result holds
    `AAT_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(total) && $stable(outcome) && $stable(slot_index))

    // dropped word reports zero sum at slot zero
    `AAT_ASSERT_NOW(a_full_zero, clk, rst_n,
        out_valid && (outcome == aat_pkg::OUTCOME_FULL),
        (total == '0) && (slot_index == '0))

    // a fresh slot starts from one amount
    `AAT_ASSERT_NOW(a_replace_narrow, clk, rst_n,
        out_valid && (outcome == aat_pkg::OUTCOME_REPLACED),
        total[aat_pkg::SUM_W-1:aat_pkg::AMT_W] == '0)

endmodule

bind aging_accumulator_table aat_checker u_aat_checker (.*);

// ----- tb/aging_accumulator_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_accumulator_table_tb
// Self-checking bench for the keyed running-sum table with age-based reuse.
// Directed rows cover reset state, key 0, hits, misses, a full table, time
// wrap and all-ones stamps.
// Then come random phases across several expiry settings, extremes included.
// Every result word is checked against a bench-side model or typed-in row.
// ----------------------------------------------------------------------------
module aging_accumulator_table_tb;

    localparam int SLOTS    = 16;
    localparam int MAX_IDLE = 12;
    localparam int DIR_N    = 22;
    localparam int PHASE_N  = 8;
    localparam int PHASE_WORDS = 118;
    localparam int POOL_N      = 24;
    localparam int DRAIN_CYCLES = 20;

    localparam int KEY_W     = aat_pkg::KEY_W;
    localparam int AMT_W     = aat_pkg::AMT_W;
    localparam int TIME_W    = aat_pkg::TIME_W;
    localparam int SUM_W     = aat_pkg::SUM_W;
    localparam int IDX_OUT_W = aat_pkg::IDX_OUT_W;

    // APB byte addresses: expiry register, and one decoded slot past the map
    localparam logic [2:0] EXPIRE_ADDR = 3'(4 * aat_pkg::REG_EXPIRE);
    localparam logic [2:0] SPARE_ADDR  = 3'd4;

    typedef struct packed {
        logic [SUM_W-1:0]     total;
        logic [1:0]           outcome;
        logic [IDX_OUT_W-1:0] slot;
    } result_t;

    // one directed row; 'fixed' rows carry their result typed in
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [AMT_W-1:0]  amt;
        logic [TIME_W-1:0] now;
        logic              fixed;
        result_t           want;
    } dir_row_t;

    // Reset state: all slots key 0, stamp 0, sum 0; expiry 10000.
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // key 0 hits cleared slot 0
        '{16'h0000, 16'h0005, 32'd0,     1'b1,
          '{31'd5,      aat_pkg::OUTCOME_UPDATED,  4'd0}},
        // nothing old enough yet: dropped
        '{16'h1234, 16'h0007, 32'd5000,  1'b1,
          '{31'd0,      aat_pkg::OUTCOME_FULL,     4'd0}},
        // all ages reach 10000, all stamps 0: lowest slot wins
        '{16'hFFFF, 16'hFFFF, 32'd10000, 1'b1,
          '{31'd65535,  aat_pkg::OUTCOME_REPLACED, 4'd0}},
        // key 0 now first found in slot 1
        '{16'h0000, 16'h0000, 32'd10000, 1'b1,
          '{31'd0,      aat_pkg::OUTCOME_UPDATED,  4'd1}},
        '{16'hFFFF, 16'hFFFF, 32'd10001, 1'b1,
          '{31'd131070, aat_pkg::OUTCOME_UPDATED,  4'd0}},
        // stamp of all ones
        '{16'h5555, 16'h8000, 32'hFFFF_FFFF, 1'b0, '0},
        // time wrapped past zero
        '{16'hAAAA, 16'h0001, 32'h0000_3000, 1'b0, '0},
        '{16'h5555, 16'h7FFF, 32'h0000_3000, 1'b0, '0},
        // hit wins even though the slot is long expired
        '{16'hFFFF, 16'h0000, 32'h0000_0000, 1'b0, '0},
        '{16'h0001, 16'h1234, 32'h8000_0000, 1'b0, '0},
        '{16'h8000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{16'h7FFF, 16'h0000, 32'h7FFF_FFFF, 1'b0, '0},
        '{16'h0002, 16'h00FF, 32'h8000_0010, 1'b0, '0},
        '{16'h0003, 16'hFF00, 32'h8000_0020, 1'b0, '0},
        '{16'h0004, 16'h0F0F, 32'h8000_0030, 1'b0, '0},
        '{16'h0005, 16'hF0F0, 32'h8000_0040, 1'b0, '0},
        '{16'h0006, 16'h3C3C, 32'h8000_0050, 1'b0, '0},
        '{16'h0007, 16'hC3C3, 32'h8000_0060, 1'b0, '0},
        '{16'h0008, 16'h0001, 32'h8000_0070, 1'b0, '0},
        '{16'h0009, 16'h0001, 32'h8000_0080, 1'b0, '0},
        '{16'h000A, 16'h0001, 32'h8000_2000, 1'b0, '0},
        '{16'h0000, 16'h0001, 32'h8000_2000, 1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [KEY_W-1:0]     entry_key;
    logic [AMT_W-1:0]     amount;
    logic [TIME_W-1:0]    now_ms;
    logic                 out_valid;
    logic                 out_ready;
    logic [SUM_W-1:0]     total;
    logic [1:0]           outcome;
    logic [IDX_OUT_W-1:0] slot_index;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    aging_accumulator_table #(
        .SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .entry_key(entry_key),
        .amount(amount),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .total(total),
        .outcome(outcome),
        .slot_index(slot_index),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Bench copy of the slot table and the expiry register.
    logic [KEY_W-1:0]  tbl_key  [SLOTS];
    logic [TIME_W-1:0] tbl_time [SLOTS];
    logic [SUM_W-1:0]  tbl_sum  [SLOTS];
    logic [TIME_W-1:0] expire_cfg;

    result_t pending_results [$];
    int      mismatch_count;
    int      words_sent;
    int      words_checked;
    int      outcome_tally [3];
    bit      no_idle;   // when set, neither side inserts gaps

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Table update for one accepted word; returns the result it must produce.
    function automatic result_t predict_entry(input logic [KEY_W-1:0] k,
                                              input logic [AMT_W-1:0] a,
                                              input logic [TIME_W-1:0] t);
        result_t           r;
        logic [SUM_W:0]    sum_next;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest;
        bit                have_victim;
        int                victim;
        have_victim = 1'b0;
        victim      = 0;
        oldest      = '0;
        for (int i = 0; i < SLOTS; i++) begin
            // first matching slot wins, whatever its age
            if (tbl_key[i] == k) begin
                sum_next = {1'b0, tbl_sum[i]} + (SUM_W + 1)'(a);
                if (sum_next > {1'b0, aat_pkg::SUM_MAX})
                    sum_next = {1'b0, aat_pkg::SUM_MAX};
                tbl_sum[i]  = sum_next[SUM_W-1:0];
                tbl_time[i] = t;
                r = '{total: sum_next[SUM_W-1:0], outcome: aat_pkg::OUTCOME_UPDATED,
                      slot: IDX_OUT_W'(i)};
                return r;
            end
            // age is modulo 2^32; oldest stamp wins, lowest index on ties
            age = t - tbl_time[i];
            if (age >= expire_cfg && (!have_victim || tbl_time[i] < oldest)) begin
                have_victim = 1'b1;
                victim      = i;
                oldest      = tbl_time[i];
            end
        end
        if (have_victim) begin
            tbl_key[victim]  = k;
            tbl_time[victim] = t;
            tbl_sum[victim]  = SUM_W'(a);
            r = '{total: SUM_W'(a), outcome: aat_pkg::OUTCOME_REPLACED,
                  slot: IDX_OUT_W'(victim)};
        end else begin
            r = '{total: '0, outcome: aat_pkg::OUTCOME_FULL, slot: '0};
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s at %0t: got 0x%0h, want 0x%0h",
                     what, $realtime, got, want);
    endtask

    // Present one word after a random gap; predict at the accepting edge.
    task automatic send_entry(input logic [KEY_W-1:0] k, input logic [AMT_W-1:0] a,
                              input logic [TIME_W-1:0] t, input bit fixed,
                              input result_t want);
        int      gap;
        result_t r;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        entry_key = k;
        amount    = a;
        now_ms    = t;
        in_valid  = 1'b1;
        do @(posedge clk); while (!in_ready);
        r = predict_entry(k, a, t);
        pending_results.push_back(fixed ? want : r);
        words_sent++;
        @(negedge clk);
        // a following send with no gap raises this again in the same step
        in_valid = 1'b0;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == EXPIRE_ADDR)
            expire_cfg = data;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== expire_cfg)
            flag_mismatch("expire_ms readback", 64'(prdata), 64'(expire_cfg));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Let every outstanding result drain, then a short settle.
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One random phase at a given expiry. A small key pool (more keys than
    // slots) keeps hits, replacements and drops all in play.
    task automatic run_phase(input logic [TIME_W-1:0] expiry, input bit calm);
        logic [KEY_W-1:0]  key_pool [POOL_N];
        logic [TIME_W-1:0] wall;
        logic [TIME_W-1:0] span;
        logic [KEY_W-1:0]  k;
        logic [AMT_W-1:0]  a;
        int                roll;
        wait_drained();
        apb_write(EXPIRE_ADDR, expiry);
        apb_read_check(EXPIRE_ADDR);
        no_idle = calm;
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = KEY_W'($urandom);
        wall = $urandom;
        // step size tracks the expiry so ages land on both sides of it
        span = (expiry < 32'd64) ? 32'd64 :
               (expiry > 32'h4000_0000) ? 32'h4000_0000 : expiry;
        for (int n = 0; n < PHASE_WORDS; n++) begin
            roll = $urandom_range(0, 63);
            if (roll == 0)
                wall = $urandom;                       // arbitrary jump
            else if (roll == 1)
                wall = wall - 1;                       // one ms back: max age
            else if (roll < 8)
                wall = wall + $urandom_range(0, span * 3);
            else
                wall = wall + $urandom_range(0, span / 4);
            roll = $urandom_range(0, POOL_N + 3);
            if (roll < POOL_N)
                k = key_pool[roll];
            else if (roll == POOL_N)
                k = '0;
            else
                k = KEY_W'($urandom);
            roll = $urandom_range(0, 7);
            a = (roll == 0) ? '0 : (roll == 1) ? '1 : AMT_W'($urandom);
            send_entry(k, a, wall, 1'b0, '0);
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stall per word, then hold ready until it moves.
    initial begin
        int gap;
        out_ready = 1'b0;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0) begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // Scoreboard: each result word against the oldest prediction.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result word with nothing pending", 64'(total), '0);
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (outcome <= aat_pkg::OUTCOME_FULL)
                    outcome_tally[outcome]++;
                if (total !== want.total)
                    flag_mismatch("total", 64'(total), 64'(want.total));
                if (outcome !== want.outcome)
                    flag_mismatch("outcome", 64'(outcome), 64'(want.outcome));
                if (slot_index !== want.slot)
                    flag_mismatch("slot_index", 64'(slot_index), 64'(want.slot));
            end
        end
    end

    // Run ceiling: ends a hung run as failed.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [TIME_W-1:0] phase_expiry [PHASE_N];
        mismatch_count = 0;
        words_sent     = 0;
        words_checked  = 0;
        outcome_tally  = '{0, 0, 0};
        no_idle        = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        entry_key      = '0;
        amount         = '0;
        now_ms         = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        expire_cfg     = aat_pkg::EXPIRE_RESET;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_key[i]  = '0;
            tbl_time[i] = '0;
            tbl_sum[i]  = '0;
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // expiry must come up at its reset value
        apb_read_check(EXPIRE_ADDR);

        for (int i = 0; i < DIR_N; i++)
            send_entry(DIR_ROWS[i].key, DIR_ROWS[i].amt, DIR_ROWS[i].now,
                       DIR_ROWS[i].fixed, DIR_ROWS[i].want);

        // write past the register map must leave expiry alone
        wait_drained();
        apb_write(SPARE_ADDR, $urandom);
        apb_read_check(EXPIRE_ADDR);

        // extremes (min, max, zero), spread, random, then the reset value
        phase_expiry = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd250, 32'd4000,
                         32'($urandom_range(1, 100000)), 32'($urandom),
                         aat_pkg::EXPIRE_RESET};
        for (int p = 0; p < PHASE_N; p++)
            run_phase(phase_expiry[p], (p % 3) == 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d words, checked %0d results over %0d expiry settings.",
                 words_sent, words_checked, PHASE_N + 1);
        $display("Outcomes seen: %0d updated, %0d replaced, %0d dropped.",
                 outcome_tally[aat_pkg::OUTCOME_UPDATED],
                 outcome_tally[aat_pkg::OUTCOME_REPLACED],
                 outcome_tally[aat_pkg::OUTCOME_FULL]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
